@@ hw/rtl/cfq_pkg.sv @@
// ----------------------------------------------------------------------------
// cfq_pkg
// Shared types and constants of the circular FIFO queue.
// ----------------------------------------------------------------------------
package cfq_pkg;

  localparam int unsigned DefDepth     = 16;
  localparam int unsigned DefDataWidth = 32;

  localparam int unsigned ReqWidth   = 2;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned CountWidth = 5;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 5;

  localparam int unsigned StartCapReset = 16;

  typedef enum logic [ReqWidth-1:0] {
    REQ_ENQ   = 2'd0,
    REQ_DEQ   = 2'd1,
    REQ_PEEK  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_GROW_ERR = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  localparam logic [CfgIdxW-1:0] CFG_START_CAP = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_GROW_MODE = 2'd1;

endpackage

@@ hw/rtl/circular_fifo_queue.sv @@
// ----------------------------------------------------------------------------
// circular_fifo_queue
// FIFO of data words kept in a ring of RAM entries, driven by requests.
// ----------------------------------------------------------------------------
// A request beat (req_type_i, in_value_i) is taken at a clock edge where
// start_i is high and busy_o is low. Each request is an enqueue, dequeue,
// peek or clear. Exactly one result beat follows in the next cycle, marked by
// done_o for a single cycle: status, front word, count and logical capacity.
// Requests can be issued every cycle while busy_o is low, so the throughput is
// one request per cycle; the front word comes from the registered RAM read.
// The words live in a single-port-write, registered-read RAM; pointers,
// count and capacity are flops, so all decisions use no RAM data. A word
// written in one cycle is visible to a read issued in the next cycle.
// The configuration port writes start capacity (index 0) or grow mode
// (index 1); either write empties the queue. Writes to other indexes are
// ignored. Reset empties the queue, restores the register defaults and
// holds busy_o high for the first cycle after reset is released.
// Results cannot be stalled by the receiver; it must take every beat.
// ----------------------------------------------------------------------------
module circular_fifo_queue
  import cfq_pkg::*;
#(
  parameter int unsigned DEPTH      = DefDepth,
  parameter int unsigned DATA_WIDTH = DefDataWidth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [ReqWidth-1:0]   req_type_i,
  input  logic [ValueWidth-1:0] in_value_i,
  output logic                  done_o,
  output logic [1:0]            status_o,
  output logic [ValueWidth-1:0] out_value_o,
  output logic [CountWidth-1:0] item_count_o,
  output logic [CountWidth-1:0] current_capacity_o,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [CfgDataW-1:0]   cfg_data_i
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastPos = AW'(DEPTH - 1);
  localparam logic [CW:0] DepthWide = (CW + 1)'(DEPTH);
  localparam logic [CW-1:0] CapReset =
      CW'((DEPTH < StartCapReset) ? DEPTH : StartCapReset);

  logic                busy_q;
  logic [CfgDataW-1:0] start_cap_q, start_cap_d;
  logic                grow_q, grow_d;
  logic [AW-1:0]       head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]       count_q, count_d, cap_q, cap_d;
  logic [CW-1:0]       req_count, req_cap;
  logic                done_q;
  status_e             status_q, status_d;
  logic                rd_q;
  logic [CW-1:0]       res_count_q, res_cap_q;

  logic                accept;
  req_e                req;
  logic                ram_we, ram_re;
  logic [CW:0]         grown;
  logic [DATA_WIDTH-1:0] ram_rdata;
  logic                cfg_hit;
  logic [CfgDataW-1:0] cap_src;

  function automatic logic [CW-1:0] limit_cap(input logic [CfgDataW-1:0] v);
    logic [CW-1:0] r;
    if (32'(v) > DEPTH) begin
      r = CW'(DEPTH);
    end else begin
      r = CW'(v);
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    if (p == LastPos) begin
      r = '0;
    end else begin
      r = p + AW'(1);
    end
    return r;
  endfunction

  assign accept = start_i & ~busy_q;
  assign req    = req_e'(req_type_i);
  assign grown  = (cap_q == '0) ? (CW + 1)'(1) : {cap_q, 1'b0};

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    req_count = count_q;
    req_cap   = cap_q;
    status_d  = ST_OK;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    if (accept) begin
      case (req)
        REQ_ENQ: begin
          if (count_q >= cap_q && !grow_q) begin
            status_d = ST_FULL;
          end else if (count_q >= cap_q && grown > DepthWide) begin
            status_d = ST_GROW_ERR;
          end else begin
            if (count_q >= cap_q) begin
              req_cap = grown[CW-1:0];
            end
            ram_we    = 1'b1;
            tail_d    = next_pos(tail_q);
            req_count = count_q + CW'(1);
          end
        end
        REQ_DEQ, REQ_PEEK: begin
          if (count_q == '0) begin
            status_d = ST_EMPTY;
          end else begin
            ram_re = 1'b1;
            if (req == REQ_DEQ) begin
              head_d    = next_pos(head_q);
              req_count = count_q - CW'(1);
            end
          end
        end
        REQ_CLEAR: begin
          head_d    = '0;
          tail_d    = '0;
          req_count = '0;
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end

    start_cap_d = start_cap_q;
    grow_d      = grow_q;
    cap_src     = start_cap_q;
    cfg_hit     = 1'b0;
    if (cfg_we_i && cfg_idx_i == CFG_START_CAP) begin
      start_cap_d = cfg_data_i;
      cap_src     = cfg_data_i;
      cfg_hit     = 1'b1;
    end else if (cfg_we_i && cfg_idx_i == CFG_GROW_MODE) begin
      grow_d  = cfg_data_i[0];
      cfg_hit = 1'b1;
    end

    count_d = req_count;
    cap_d   = req_cap;
    if (cfg_hit) begin
      head_d  = '0;
      tail_d  = '0;
      count_d = '0;
      cap_d   = limit_cap(cap_src);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b1;
      start_cap_q <= CfgDataW'(StartCapReset);
      grow_q      <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      cap_q       <= CapReset;
      done_q      <= 1'b0;
      status_q    <= ST_OK;
      rd_q        <= 1'b0;
      res_count_q <= '0;
      res_cap_q   <= '0;
    end else begin
      busy_q      <= 1'b0;
      start_cap_q <= start_cap_d;
      grow_q      <= grow_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      cap_q       <= cap_d;
      done_q      <= accept;
      status_q    <= status_d;
      rd_q        <= ram_re;
      res_count_q <= req_count;
      res_cap_q   <= req_cap;
    end
  end

  cfq_ram #(
    .Width (DATA_WIDTH),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (DATA_WIDTH'(in_value_i)),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  assign busy_o             = busy_q;
  assign done_o             = done_q;
  assign status_o           = status_q;
  assign out_value_o        = rd_q ? ValueWidth'(ram_rdata) : '0;
  assign item_count_o       = CountWidth'(res_count_q);
  assign current_capacity_o = CountWidth'(res_cap_q);

endmodule

@@ hw/rtl/cfq_ram.sv @@
// ----------------------------------------------------------------------------
// cfq_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module cfq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/cfq_checker.sv @@
// ----------------------------------------------------------------------------
// cfq_checker
// Port-level checks of the circular FIFO queue, bound to its top level.
// ----------------------------------------------------------------------------
module cfq_checker
  import cfq_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start_i,
  input logic                  busy_o,
  input logic [ReqWidth-1:0]   req_type_i,
  input logic                  done_o,
  input logic [1:0]            status_o,
  input logic [ValueWidth-1:0] out_value_o,
  input logic [CountWidth-1:0] item_count_o,
  input logic [CountWidth-1:0] current_capacity_o
);

  // Every accepted request beat gives a result beat in the next cycle.
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (start_i && !busy_o) |=> done_o)
    else $error("result beat missing after accepted request");

  // No result beat appears without a request accepted in the cycle before.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
      !(start_i && !busy_o) |=> !done_o)
    else $error("result beat without request");

  // An empty report never carries a word.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (done_o && status_o == ST_EMPTY) |-> (out_value_o == '0))
    else $error("empty result carries a nonzero word");

  // A full report means the queue holds exactly its capacity.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (done_o && status_o == ST_FULL) |-> (item_count_o == current_capacity_o))
    else $error("full result with count below capacity");

  // An accepted enqueue or clear never returns a word.
  a_enq_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (start_i && !busy_o && (req_type_i == REQ_ENQ || req_type_i == REQ_CLEAR))
      |=> (out_value_o == '0))
    else $error("enqueue or clear result carries a word");

endmodule

bind circular_fifo_queue cfq_checker u_cfq_checker (.*);

@@ bench/tb_circular_fifo_queue.sv @@
// ----------------------------------------------------------------------------
// tb_circular_fifo_queue
// Self-checking testbench of the circular FIFO queue.
// ----------------------------------------------------------------------------
// A driver feeds request beats and register writes from a planned list,
// with random idle cycles and pauses until the queue has answered everything.
// A monitor keeps its own model of the queue, predicts every result beat at
// the moment a request is taken, and compares each result beat field by field
// in order. A short directed run covers empty, full, clear, zero capacity,
// growth and ignored register writes; random phases with changing settings
// follow.
// ----------------------------------------------------------------------------
module tb_circular_fifo_queue;
  timeunit 1ns;
  timeprecision 1ps;
  import cfq_pkg::*;

  localparam int CycleLimit = 400_000;
  localparam int RandomRequests = 1800;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 2'd3;

  typedef enum logic [1:0] {
    BEAT_REQ,
    BEAT_CFG,
    BEAT_DRAIN
  } beat_kind_e;

  typedef struct {
    beat_kind_e           kind;
    req_e                 req;
    logic [ValueWidth-1:0] value;
    logic [CfgIdxW-1:0]   idx;
    logic [CfgDataW-1:0]  data;
    int                   gap;
  } plan_entry_t;

  typedef struct packed {
    status_e               status;
    logic [ValueWidth-1:0] value;
    logic [CountWidth-1:0] count;
    logic [CountWidth-1:0] capacity;
  } queue_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start_i = 1'b0;
  logic                  busy_o;
  logic [ReqWidth-1:0]   req_type_i = '0;
  logic [ValueWidth-1:0] in_value_i = '0;
  logic                  done_o;
  logic [1:0]            status_o;
  logic [ValueWidth-1:0] out_value_o;
  logic [CountWidth-1:0] item_count_o;
  logic [CountWidth-1:0] current_capacity_o;
  logic                  cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]    cfg_idx_i = '0;
  logic [CfgDataW-1:0]   cfg_data_i = '0;

  plan_entry_t           plan[$];
  queue_result_t         pending_results[$];
  int                    in_flight = 0;
  int                    mismatches = 0;
  int                    cycles = 0;

  logic [ValueWidth-1:0] model_words[$];
  int                    model_cap = StartCapReset;
  logic [CfgDataW-1:0]   cfg_start_cap = CfgDataW'(StartCapReset);
  logic                  cfg_grow = 1'b0;

  circular_fifo_queue dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .req_type_i         (req_type_i),
    .in_value_i         (in_value_i),
    .done_o             (done_o),
    .status_o           (status_o),
    .out_value_o        (out_value_o),
    .item_count_o       (item_count_o),
    .current_capacity_o (current_capacity_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic void write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    if (idx == CFG_START_CAP) begin
      cfg_start_cap = data;
    end else if (idx == CFG_GROW_MODE) begin
      cfg_grow = data[0];
    end else begin
      return;
    end
    model_words.delete();
    model_cap = (cfg_start_cap > DefDepth) ? DefDepth : cfg_start_cap;
  endfunction

  function automatic queue_result_t serve_request(req_e kind, logic [ValueWidth-1:0] word);
    queue_result_t res;
    int            grown;
    res.status = ST_OK;
    res.value  = '0;
    case (kind)
      REQ_ENQ: begin
        if (model_words.size() >= model_cap) begin
          if (!cfg_grow) begin
            res.status = ST_FULL;
          end else begin
            grown = (model_cap == 0) ? 1 : model_cap * 2;
            if (grown > DefDepth) begin
              res.status = ST_GROW_ERR;
            end else begin
              model_cap = grown;
            end
          end
        end
        if (res.status == ST_OK) begin
          model_words.push_back(word);
        end
      end
      REQ_DEQ, REQ_PEEK: begin
        if (model_words.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.value = model_words[0];
          if (kind == REQ_DEQ) begin
            void'(model_words.pop_front());
          end
        end
      end
      default: begin
        model_words.delete();
      end
    endcase
    res.count    = CountWidth'(model_words.size());
    res.capacity = CountWidth'(model_cap);
    return res;
  endfunction

  function automatic void check_field(string field, logic [ValueWidth-1:0] want,
                                      logic [ValueWidth-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : drive_proc
    logic nxt_start;
    logic nxt_we;
    int   gap_cnt;
    if (!rst_ni) begin
      start_i  <= 1'b0;
      cfg_we_i <= 1'b0;
      gap_cnt  = 0;
    end else begin
      if (start_i && !busy_o) begin
        in_flight++;
      end
      if (done_o) begin
        in_flight--;
      end
      nxt_start = start_i && busy_o;
      nxt_we    = 1'b0;
      if (!nxt_start && plan.size() > 0) begin
        if (gap_cnt < plan[0].gap) begin
          gap_cnt++;
        end else begin
          case (plan[0].kind)
            BEAT_REQ: begin
              nxt_start = 1'b1;
              req_type_i <= plan[0].req;
              in_value_i <= plan[0].value;
              void'(plan.pop_front());
              gap_cnt = 0;
            end
            BEAT_CFG: begin
              if (in_flight == 0) begin
                nxt_we = 1'b1;
                cfg_idx_i  <= plan[0].idx;
                cfg_data_i <= plan[0].data;
                void'(plan.pop_front());
                gap_cnt = 0;
              end
            end
            default: begin
              if (in_flight == 0) begin
                void'(plan.pop_front());
                gap_cnt = 0;
              end
            end
          endcase
        end
      end
      start_i  <= nxt_start;
      cfg_we_i <= nxt_we;
    end
  end

  always @(posedge clk_i) begin : check_proc
    queue_result_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with nothing expected, status %0d value %0h",
                   $time, status_o, out_value_o);
        end else begin
          want = pending_results.pop_front();
          check_field("status", ValueWidth'(want.status), ValueWidth'(status_o));
          check_field("out_value", want.value, out_value_o);
          check_field("item_count", ValueWidth'(want.count), ValueWidth'(item_count_o));
          check_field("current_capacity", ValueWidth'(want.capacity),
                      ValueWidth'(current_capacity_o));
        end
      end
      if (cfg_we_i) begin
        write_register(cfg_idx_i, cfg_data_i);
      end
      if (start_i && !busy_o) begin
        pending_results.push_back(serve_request(req_e'(req_type_i), in_value_i));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_circular_fifo_queue: FAIL");
      $finish;
    end
  end

  task automatic add_request(req_e req, logic [ValueWidth-1:0] value, int gap);
    plan_entry_t e;
    e.kind  = BEAT_REQ;
    e.req   = req;
    e.value = value;
    e.idx   = '0;
    e.data  = '0;
    e.gap   = gap;
    plan.push_back(e);
  endtask

  task automatic add_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    plan_entry_t e;
    e.kind  = BEAT_CFG;
    e.req   = REQ_ENQ;
    e.value = '0;
    e.idx   = idx;
    e.data  = data;
    e.gap   = $urandom_range(0, 3);
    plan.push_back(e);
  endtask

  task automatic add_drain();
    plan_entry_t e;
    e.kind  = BEAT_DRAIN;
    e.req   = REQ_ENQ;
    e.value = '0;
    e.idx   = '0;
    e.data  = '0;
    e.gap   = 0;
    plan.push_back(e);
  endtask

  initial begin
    int                    random_reqs;
    int                    phase_no;
    int                    len;
    int                    enq_pct;
    int                    gap_mode;
    int                    roll;
    int                    gap;
    int                    sel;
    logic [CfgDataW-1:0]   cap_data;
    logic                  grow_bit;
    logic [ValueWidth-1:0] word;
    req_e                  req;

    add_request(REQ_DEQ, 32'hFFFF_FFFF, 0);
    add_request(REQ_PEEK, '0, 0);
    add_request(REQ_ENQ, '0, 0);
    add_request(REQ_ENQ, 32'hFFFF_FFFF, 1);
    add_request(REQ_PEEK, '0, 0);
    add_request(REQ_DEQ, '0, 0);
    add_request(REQ_DEQ, '0, 2);
    add_request(REQ_DEQ, '0, 0);
    add_request(REQ_ENQ, 32'h1234_5678, 0);
    add_request(REQ_CLEAR, 32'hA5A5_A5A5, 0);
    add_request(REQ_PEEK, '0, 0);
    add_drain();
    add_write(CFG_START_CAP, 5'd0);
    add_request(REQ_ENQ, 32'h0000_0001, 0);
    add_request(REQ_DEQ, '0, 0);
    add_write(CFG_GROW_MODE, 5'd1);
    add_request(REQ_ENQ, 32'h8000_0000, 0);
    add_request(REQ_ENQ, 32'h7FFF_FFFF, 0);
    add_request(REQ_ENQ, 32'h5555_5555, 0);
    add_write(CFG_SPARE_HI, 5'd31);
    add_request(REQ_PEEK, '0, 0);
    add_request(REQ_DEQ, '0, 0);
    add_write(CFG_START_CAP, 5'd31);
    add_write(CFG_GROW_MODE, 5'd0);
    add_request(REQ_ENQ, 32'hDEAD_BEEF, 0);
    add_request(REQ_DEQ, '0, 0);
    add_write(CFG_START_CAP, 5'd1);
    add_request(REQ_ENQ, 32'h0F0F_0F0F, 0);
    add_request(REQ_ENQ, 32'hF0F0_F0F0, 0);
    add_request(REQ_CLEAR, '0, 0);

    random_reqs = 0;
    phase_no = 0;
    while (random_reqs < RandomRequests) begin
      case (phase_no)
        0: cap_data = 5'd0;
        1: cap_data = 5'd16;
        2: cap_data = 5'd31;
        3: cap_data = 5'd0;
        4: cap_data = 5'd16;
        5: cap_data = 5'd1;
        default: cap_data = CfgDataW'($urandom_range(0, 31));
      endcase
      grow_bit = (phase_no < 6) ? phase_no[0] : 1'($urandom_range(0, 1));
      if ($urandom_range(0, 1)) begin
        add_write(CFG_START_CAP, cap_data);
        add_write(CFG_GROW_MODE, {4'($urandom_range(0, 15)), grow_bit});
      end else begin
        add_write(CFG_GROW_MODE, {4'($urandom_range(0, 15)), grow_bit});
        add_write(CFG_START_CAP, cap_data);
      end
      if ($urandom_range(0, 3) == 0) begin
        add_write($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                  CfgDataW'($urandom_range(0, 31)));
      end
      enq_pct  = $urandom_range(25, 85);
      len      = $urandom_range(20, 120);
      gap_mode = $urandom_range(0, 2);
      for (int i = 0; i < len; i++) begin
        roll = $urandom_range(0, 99);
        if (roll >= 97) begin
          req = REQ_CLEAR;
        end else if (roll < enq_pct) begin
          req = REQ_ENQ;
        end else begin
          req = $urandom_range(0, 1) ? REQ_DEQ : REQ_PEEK;
        end
        sel = $urandom_range(0, 9);
        word = (sel == 0) ? '0 : (sel == 1) ? '1 : $urandom;
        case (gap_mode)
          0: gap = 0;
          1: gap = $urandom_range(0, 17);
          default: gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
        endcase
        add_request(req, word, gap);
        random_reqs++;
        if ($urandom_range(0, 49) == 0) begin
          add_drain();
        end
      end
      phase_no++;
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    do begin
      @(negedge clk_i);
    end while (plan.size() != 0 || in_flight != 0 || start_i);
    repeat (4) @(negedge clk_i);

    if (pending_results.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected result beats never arrived", $time, pending_results.size());
    end
    if (mismatches == 0) begin
      $display("tb_circular_fifo_queue: PASS");
    end else begin
      $display("tb_circular_fifo_queue: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/cfq_pkg.sv
hw/rtl/cfq_ram.sv
hw/rtl/circular_fifo_queue.sv
hw/rtl/cfq_checker.sv
bench/tb_circular_fifo_queue.sv
